// ----- hw/rtl/csd_pkg.sv -----
// Package for the complex spectrum divider: widths, register indexes,
// pipeline word types and the one-bit restoring division step. No dependencies.
`timescale 1ns / 1ps
package csd_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int MAG_W          = 2 * COMPONENT_BITS;
    localparam int INT_BITS       = 7;
    localparam int FRAC_BITS      = 17;
    localparam int QBITS          = INT_BITS + FRAC_BITS;
    localparam int OUT_W          = 24;
    localparam int BIAS_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CONJUGATE_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEN_BIAS       = CFG_IDX_W'(1);

    localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;

    // Sign and magnitude of one numerator
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } smag_t;

    // Word leaving the front end
    typedef struct packed {
        smag_t            re;
        smag_t            im;
        logic [MAG_W-1:0] den;
        logic             ronly;
    } front_t;

    // One division lane
    typedef struct packed {
        logic [MAG_W-1:0]    rem;
        logic [QBITS-1:0]    quo;
        logic [INT_BITS-1:0] low_bits;
        logic                neg;
        logic                sat;
    } lane_t;

    // Word travelling down the divider
    typedef struct packed {
        lane_t            re;
        lane_t            im;
        logic [MAG_W-1:0] den;
        logic             zd;
        logic             ronly;
    } div_t;

    // Restoring step: bring in the next dividend bit, produce one quotient bit
    function automatic lane_t div_bit(lane_t l, logic [MAG_W-1:0] den);
        lane_t          o;
        logic [MAG_W:0] trial;
        logic           take;
        o     = l;
        trial = {l.rem, l.low_bits[INT_BITS-1]};
        take  = (trial >= {1'b0, den});
        if (take)
        begin
            trial = trial - {1'b0, den};
        end
        o.rem      = trial[MAG_W-1:0];
        o.quo      = {l.quo[QBITS-2:0], take};
        o.low_bits = {l.low_bits[INT_BITS-2:0], 1'b0};
        return o;
    endfunction

endpackage

// ----- hw/rtl/complex_spectrum_divide_core.sv -----
// Top level of the complex spectrum divider: configuration registers,
// front end and pipelined divider. Depends on csd_pkg, csd_front, csd_divider.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | in
//  in      | in_valid in_ready a_real a_imag b_real b_imag    | in
//          | real_only                                        |
//  out     | out_valid out_ready quot_real quot_imag          | out
//          | zero_divisor                                     |
//
// One word enters per cycle unless out stalls; it passes two front-end stages,
// one set-up stage, 24 one-bit division stages and the output register.
// The whole pipeline advances together; a stall on out freezes every stage
// and drops in_ready, so nothing is lost or repeated.
// Reset clears valid bits and sets conjugate_mode to 0, denominator_bias to 1.
`timescale 1ns / 1ps
module complex_spectrum_divide_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  csd_pkg::comp_t                     a_real,
    input  csd_pkg::comp_t                     a_imag,
    input  csd_pkg::comp_t                     b_real,
    input  csd_pkg::comp_t                     b_imag,
    input  logic                               real_only,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [csd_pkg::OUT_W-1:0]   quot_real,
    output logic signed [csd_pkg::OUT_W-1:0]   quot_imag,
    output logic                               zero_divisor
);
    import csd_pkg::*;

    logic              conj_reg;
    logic [BIAS_W-1:0] bias_reg;
    logic              advance;
    logic              front_valid;
    front_t            front_word;

    // Advance the pipeline unless the output word is held
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    // Configuration writes; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conj_reg <= 1'b0;
            bias_reg <= BIAS_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CONJUGATE_MODE: conj_reg <= cfg_data[0];
                REG_DEN_BIAS:       bias_reg <= cfg_data[BIAS_W-1:0];
                default:            ;
            endcase
        end
    end

    csd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .real_only (real_only),
        .conj      (conj_reg),
        .bias      (bias_reg),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    csd_divider u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .in_valid     (front_valid),
        .in_word      (front_word),
        .out_valid    (out_valid),
        .quot_real    (quot_real),
        .quot_imag    (quot_imag),
        .zero_divisor (zero_divisor)
    );

endmodule

// ----- hw/rtl/csd_front.sv -----
// Front end: products in the first stage, numerators and divisor in the second.
// Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  csd_pkg::comp_t                a_real,
    input  csd_pkg::comp_t                a_imag,
    input  csd_pkg::comp_t                b_real,
    input  csd_pkg::comp_t                b_imag,
    input  logic                          real_only,
    input  logic                          conj,
    input  logic [csd_pkg::BIAS_W-1:0]    bias,
    output logic                          out_valid,
    output csd_pkg::front_t               out_word
);
    import csd_pkg::*;

    logic signed [MAG_W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, s_rr_reg, s_ii_reg;
    comp_t                   ar_reg, br_reg;
    logic                    ronly_reg, conj_reg, va_reg;
    logic [BIAS_W-1:0]       bias_reg;
    front_t                  word_next, word_reg;
    logic                    vb_reg;

    // Stage A: hold products of the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg  <= a_real * b_real;
            p_ii_reg  <= a_imag * b_imag;
            p_ir_reg  <= a_imag * b_real;
            p_ri_reg  <= a_real * b_imag;
            s_rr_reg  <= b_real * b_real;
            s_ii_reg  <= b_imag * b_imag;
            ar_reg    <= a_real;
            br_reg    <= b_real;
            ronly_reg <= real_only;
            conj_reg  <= conj;
            bias_reg  <= bias;
            word_reg  <= word_next;
        end
    end

    // Stage B: combine products into signed numerators and the divisor, or use a_real, b_real if real-only
    always_comb
    begin
        logic signed [MAG_W:0]   sre, sim;
        logic signed [MAG_W-1:0] arx, brx;
        sre = conj_reg ? (MAG_W+1)'(p_rr_reg) - (MAG_W+1)'(p_ii_reg)
                       : (MAG_W+1)'(p_rr_reg) + (MAG_W+1)'(p_ii_reg);
        sim = conj_reg ? (MAG_W+1)'(p_ir_reg) + (MAG_W+1)'(p_ri_reg)
                       : (MAG_W+1)'(p_ir_reg) - (MAG_W+1)'(p_ri_reg);
        arx = MAG_W'(ar_reg);
        brx = MAG_W'(br_reg);
        word_next.ronly = ronly_reg;
        if (ronly_reg)
        begin
            word_next.re.mag = arx[MAG_W-1] ? MAG_W'(-arx) : MAG_W'(arx);
            word_next.re.neg = ar_reg[COMPONENT_BITS-1] ^ br_reg[COMPONENT_BITS-1];
            word_next.im.mag = '0;
            word_next.im.neg = 1'b0;
            word_next.den    = brx[MAG_W-1] ? MAG_W'(-brx) : MAG_W'(brx);
        end
        else
        begin
            word_next.re.mag = sre[MAG_W] ? MAG_W'(-sre) : MAG_W'(sre);
            word_next.re.neg = sre[MAG_W];
            word_next.im.mag = sim[MAG_W] ? MAG_W'(-sim) : MAG_W'(sim);
            word_next.im.neg = sim[MAG_W];
            word_next.den    = MAG_W'(s_rr_reg) + MAG_W'(s_ii_reg) + MAG_W'(bias_reg);
        end
    end

    assign out_valid = vb_reg;
    assign out_word  = word_reg;

endmodule

// ----- hw/rtl/csd_div_step.sv -----
// One registered restoring-division stage for both lanes.
// Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  csd_pkg::div_t in_word,
    output logic          out_valid,
    output csd_pkg::div_t out_word
);
    import csd_pkg::*;

    logic valid_reg;
    div_t word_reg, word_next;

    // Work out one quotient bit per lane
    always_comb
    begin
        word_next    = in_word;
        word_next.re = div_bit(in_word.re, in_word.den);
        word_next.im = div_bit(in_word.im, in_word.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- hw/rtl/csd_divider.sv -----
// Divider: overflow check, a chain of one-bit stages, rounding and saturation.
// Depends on csd_pkg and csd_div_step.
`timescale 1ns / 1ps
module csd_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  csd_pkg::front_t                 in_word,
    output logic                            out_valid,
    output logic signed [csd_pkg::OUT_W-1:0] quot_real,
    output logic signed [csd_pkg::OUT_W-1:0] quot_imag,
    output logic                            zero_divisor
);
    import csd_pkg::*;

    div_t                     chain_word [QBITS+1];
    logic                     chain_valid [QBITS+1];
    div_t                     init_next;
    logic                     init_valid_reg, out_valid_reg;
    div_t                     init_reg;
    logic signed [OUT_W-1:0]  qr_reg, qi_reg;
    logic                     zd_reg;

    // Set up one lane: saturate on a zero divisor or when the integer part would reach 2^INT_BITS
    function automatic lane_t lane_init(smag_t n, logic [MAG_W-1:0] den);
        lane_t l;
        l.rem      = n.mag >> INT_BITS;
        l.low_bits = n.mag[INT_BITS-1:0];
        l.quo      = '0;
        l.neg      = n.neg;
        l.sat      = (den == '0) ||
                     ({{INT_BITS{1'b0}}, n.mag} >= {den, {INT_BITS{1'b0}}});
        return l;
    endfunction

    // Round half away from zero on the magnitude, then clamp
    function automatic logic signed [OUT_W-1:0] lane_final(lane_t l);
        logic [QBITS:0] r;
        r = ({1'b0, l.quo} + (QBITS+1)'(1)) >> 1;
        if (l.sat)
        begin
            return l.neg ? Q_MIN : Q_MAX;
        end
        else if (l.neg)
        begin
            return (r > (QBITS+1)'(1 << (OUT_W-1))) ? Q_MIN : OUT_W'(-r);
        end
        else
        begin
            return (r > (QBITS+1)'(Q_MAX)) ? Q_MAX : OUT_W'(r);
        end
    endfunction

    always_comb
    begin
        init_next.re    = lane_init(in_word.re, in_word.den);
        init_next.im    = lane_init(in_word.im, in_word.den);
        init_next.den   = in_word.den;
        init_next.zd    = (in_word.den == '0);
        init_next.ronly = in_word.ronly;
    end

    // Initial stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            init_valid_reg <= in_valid;
            out_valid_reg  <= chain_valid[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            init_reg <= init_next;
            qr_reg   <= lane_final(chain_word[QBITS].re);
            qi_reg   <= chain_word[QBITS].ronly ? '0 : lane_final(chain_word[QBITS].im);
            zd_reg   <= chain_word[QBITS].zd;
        end
    end

    assign chain_word[0]  = init_reg;
    assign chain_valid[0] = init_valid_reg;

    // One stage per quotient bit
    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        csd_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[k]),
            .in_word   (chain_word[k]),
            .out_valid (chain_valid[k+1]),
            .out_word  (chain_word[k+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign quot_real    = qr_reg;
    assign quot_imag    = qi_reg;
    assign zero_divisor = zd_reg;

endmodule
